[design/pal_pkg.sv]
// Shared types and constants for the positional array list.
package pal_pkg;

   localparam int unsigned DEF_CAPACITY   = 16;
   localparam int unsigned DEF_DATA_WIDTH = 32;

   localparam int unsigned OP_W     = 3;
   localparam int unsigned POS_W    = 4;
   localparam int unsigned ITEM_W   = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 3'd0,
      OP_DELETE   = 3'd1,
      OP_RETRIEVE = 3'd2,
      OP_LOCATE   = 3'd3,
      OP_PRINT    = 3'd4,
      OP_CLEAR    = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_REJECTED  = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FLUSH
   } state_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [POS_W-1:0] pos;
   } cell_ctrl_type;

endpackage

[design/pal_cell.sv]
// One list cell: holds an entry and shifts with its neighbors on insert or delete.
module pal_cell #(
   parameter int unsigned DATA_WIDTH = pal_pkg::DEF_DATA_WIDTH,
   parameter int unsigned INDEX      = 0
) (
   input  logic                    clock,
   input  pal_pkg::cell_ctrl_type  ctrl,
   input  logic [DATA_WIDTH-1:0]   new_value,
   input  logic [DATA_WIDTH-1:0]   lower_value,
   input  logic [DATA_WIDTH-1:0]   upper_value,
   output logic [DATA_WIDTH-1:0]   value
);
   import pal_pkg::*;

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic                  above;
   logic                  at_pos;

   assign above  = INDEX > int'(unsigned'(ctrl.pos));
   assign at_pos = INDEX == int'(unsigned'(ctrl.pos));

   always_comb begin
      value_in = value_ff;
      if (ctrl.ins) begin
         if (above) value_in = lower_value;
         else if (at_pos) value_in = new_value;
      end else if (ctrl.del) begin
         if (above || at_pos) value_in = upper_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[design/pal_chain.sv]
// Row of list cells with a single read port selected by index.
module pal_chain #(
   parameter int unsigned CAPACITY   = pal_pkg::DEF_CAPACITY,
   parameter int unsigned DATA_WIDTH = pal_pkg::DEF_DATA_WIDTH,
   parameter int unsigned IDX_W      = $clog2(CAPACITY)
) (
   input  logic                    clock,
   input  pal_pkg::cell_ctrl_type  ctrl,
   input  logic [DATA_WIDTH-1:0]   new_value,
   input  logic [IDX_W-1:0]        rd_addr,
   output logic [DATA_WIDTH-1:0]   rd_data
);
   import pal_pkg::*;

   logic [DATA_WIDTH-1:0] cell_value [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower;
      logic [DATA_WIDTH-1:0] upper;

      if (i == 0) begin : g_first
         assign lower = cell_value[0];
      end else begin : g_mid_lo
         assign lower = cell_value[i-1];
      end
      // the top cell keeps its value when the list shifts down
      if (i == CAPACITY - 1) begin : g_last
         assign upper = cell_value[i];
      end else begin : g_mid_hi
         assign upper = cell_value[i+1];
      end

      pal_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (new_value),
         .lower_value (lower),
         .upper_value (upper),
         .value       (cell_value[i])
      );
   end

   assign rd_data = cell_value[rd_addr];

endmodule

[design/positional_array_list.sv]
// A single-result request is executed in S_EXEC; its result is then registered.
// A new request is accepted only while the controller is idle, not while busy.
// Locate and print scan one cell per cycle: one result per match (print matches every entry), or one not-found result.
// Reset: synchronous; empties the list and idles the controller; cell contents stay undefined.
// Results are registered and shown for exactly one cycle on rsp_strobe.
module positional_array_list #(
   parameter int unsigned CAPACITY   = pal_pkg::DEF_CAPACITY,
   parameter int unsigned DATA_WIDTH = pal_pkg::DEF_DATA_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pal_pkg::OP_W-1:0]             req_operation,
   input  logic [pal_pkg::POS_W-1:0]            req_position,
   input  logic signed [pal_pkg::ITEM_W-1:0]    req_item_value,
   output logic                                 rsp_strobe,
   output logic [pal_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pal_pkg::POS_W-1:0]            rsp_found_position,
   output logic signed [pal_pkg::ITEM_W-1:0]    rsp_entry_value,
   output logic [pal_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic                                 rsp_last_of_run
);
   import pal_pkg::*;

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type                     state_ff, state_in;
   op_type                        op_ff;
   logic [POS_W-1:0]              pos_ff;
   logic signed [DATA_WIDTH-1:0]  val_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              scan_idx_ff, scan_idx_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]              pend_pos_ff, pend_pos_in;
   logic signed [DATA_WIDTH-1:0]  pend_val_ff, pend_val_in;

   logic                          rsp_strobe_ff, rsp_strobe_in;
   status_type                    rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]              rsp_pos_ff, rsp_pos_in;
   logic signed [DATA_WIDTH-1:0]  rsp_val_ff, rsp_val_in;
   logic [COUNT_W-1:0]            rsp_count_ff;
   logic                          rsp_last_ff, rsp_last_in;

   cell_ctrl_type                 ctrl;
   logic [IDX_W-1:0]              rd_addr;
   logic signed [DATA_WIDTH-1:0]  rd_data;

   logic                          accept;
   logic                          empty;
   logic                          full;
   logic                          pos_beyond;
   logic                          pos_outside;
   logic                          scan_end;
   logic                          hit;

   assign accept      = start && (state_ff == S_IDLE);
   assign empty       = count_ff == '0;
   assign full        = count_ff == CNT_W'(CAPACITY);
   assign pos_beyond  = CMP_W'(pos_ff) > CMP_W'(count_ff);
   assign pos_outside = CMP_W'(pos_ff) >= CMP_W'(count_ff);
   assign scan_end    = CNT_W'(scan_idx_ff) == (count_ff - CNT_W'(1));
   assign hit         = (op_ff == OP_PRINT) || (rd_data == val_ff);

   pal_chain #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W)
   ) u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .new_value (val_ff),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_pos_in   = pend_pos_ff;
      pend_val_in   = pend_val_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_pos_in    = '0;
      rsp_val_in    = '0;
      rsp_last_in   = 1'b1;
      ctrl.ins      = 1'b0;
      ctrl.del      = 1'b0;
      ctrl.pos      = pos_ff;
      rd_addr       = IDX_W'(pos_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            rsp_strobe_in = 1'b1;
            rsp_pos_in    = pos_ff;
            state_in      = S_IDLE;
            unique case (op_ff)
               OP_INSERT: begin
                  rsp_val_in = val_ff;
                  if (full || pos_beyond) begin
                     rsp_status_in = ST_REJECTED;
                  end else begin
                     ctrl.ins = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               OP_DELETE, OP_RETRIEVE: begin
                  if (empty) begin
                     rsp_status_in = ST_EMPTY;
                  end else if (pos_outside) begin
                     rsp_status_in = ST_REJECTED;
                  end else begin
                     rsp_val_in = rd_data;
                     if (op_ff == OP_DELETE) begin
                        ctrl.del = 1'b1;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
               end
               OP_LOCATE, OP_PRINT: begin
                  rsp_pos_in = '0;
                  if (empty) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rsp_strobe_in = 1'b0;
                     scan_idx_in   = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_SCAN;
                  end
               end
               OP_CLEAR: begin
                  rsp_pos_in = '0;
                  count_in   = '0;
               end
               default: begin
                  rsp_pos_in    = '0;
                  rsp_status_in = ST_REJECTED;
               end
            endcase
         end
         S_SCAN: begin
            // a match is held back until the next match or the flush so the final one can carry last_of_run
            rd_addr = scan_idx_ff;
            if (hit) begin
               rsp_strobe_in = pend_valid_ff;
               rsp_pos_in    = POS_W'(pend_pos_ff);
               rsp_val_in    = pend_val_ff;
               rsp_last_in   = 1'b0;
               pend_valid_in = 1'b1;
               pend_pos_in   = scan_idx_ff;
               pend_val_in   = rd_data;
            end
            if (scan_end) state_in = S_FLUSH;
            else scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
         S_FLUSH: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            if (pend_valid_ff) begin
               rsp_pos_in = POS_W'(pend_pos_ff);
               rsp_val_in = pend_val_ff;
            end else begin
               rsp_status_in = ST_NOT_FOUND;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_operation);
         pos_ff <= req_position;
         val_ff <= DATA_WIDTH'(req_item_value);
      end
      scan_idx_ff   <= scan_idx_in;
      pend_pos_ff   <= pend_pos_in;
      pend_val_ff   <= pend_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_count_ff  <= COUNT_W'(count_in);
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy               = state_ff != S_IDLE;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_entry_value    = ITEM_W'(rsp_val_ff);
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_last_of_run    = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_exec_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && !(op_ff == OP_LOCATE || op_ff == OP_PRINT)) |=> rsp_strobe_ff)
      else $error("single-result request gave no result");

   a_scan_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |=> (!rsp_strobe_ff || !rsp_last_ff))
      else $error("last_of_run set before scan finished");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff == OP_INSERT && !ctrl.ins) |=> $stable(count_ff))
      else $error("rejected insert changed fill count");

endmodule

[sim/positional_array_list_checker.sv]
// Watches the list's request and result ports, predicts every result and compares.
`timescale 1ns / 1ps

module positional_array_list_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [pal_pkg::OP_W-1:0]          req_operation,
   input  logic [pal_pkg::POS_W-1:0]         req_position,
   input  logic signed [pal_pkg::ITEM_W-1:0] req_item_value,
   input  logic                              rsp_strobe,
   input  logic [pal_pkg::STATUS_W-1:0]      rsp_status,
   input  logic [pal_pkg::POS_W-1:0]         rsp_found_position,
   input  logic signed [pal_pkg::ITEM_W-1:0] rsp_entry_value,
   input  logic [pal_pkg::COUNT_W-1:0]       rsp_entry_count,
   input  logic                              rsp_last_of_run,
   output int                                fail_count,
   output int                                pending,
   output int                                list_size
);
   import pal_pkg::*;

   typedef struct {
      status_type               status;
      logic [POS_W-1:0]         position;
      logic signed [ITEM_W-1:0] value;
      logic [COUNT_W-1:0]       count;
      logic                     last;
   } list_result_type;

   logic signed [ITEM_W-1:0] shadow_list [DEF_CAPACITY];
   int unsigned              shadow_count;
   list_result_type          queued_results [$];

   initial begin
      fail_count   = 0;
      pending      = 0;
      list_size    = 0;
      shadow_count = 0;
   end

   task automatic report(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic push_result(input status_type status, input int unsigned position,
                              input logic signed [ITEM_W-1:0] value, input logic last);
      list_result_type r;
      r.status   = status;
      r.position = position[POS_W-1:0];
      r.value    = value;
      r.count    = shadow_count[COUNT_W-1:0];
      r.last     = last;
      queued_results.push_back(r);
   endtask

   task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [ITEM_W-1:0] val);
      int unsigned              hits [$];
      int unsigned              i;
      logic signed [ITEM_W-1:0] removed;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= DEF_CAPACITY || pos > shadow_count) begin
               push_result(ST_REJECTED, pos, val, 1'b1);
            end else begin
               for (i = shadow_count; i > pos; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[pos] = val;
               shadow_count++;
               push_result(ST_OK, pos, val, 1'b1);
            end
         end
         OP_DELETE: begin
            if (shadow_count == 0) begin
               push_result(ST_EMPTY, pos, '0, 1'b1);
            end else if (pos >= shadow_count) begin
               push_result(ST_REJECTED, pos, '0, 1'b1);
            end else begin
               removed = shadow_list[pos];
               for (i = pos; i + 1 < shadow_count; i++)
                  shadow_list[i] = shadow_list[i+1];
               shadow_count--;
               push_result(ST_OK, pos, removed, 1'b1);
            end
         end
         OP_RETRIEVE: begin
            if (shadow_count == 0)
               push_result(ST_EMPTY, pos, '0, 1'b1);
            else if (pos >= shadow_count)
               push_result(ST_REJECTED, pos, '0, 1'b1);
            else
               push_result(ST_OK, pos, shadow_list[pos], 1'b1);
         end
         OP_LOCATE: begin
            if (shadow_count == 0) begin
               push_result(ST_EMPTY, 0, '0, 1'b1);
            end else begin
               for (i = 0; i < shadow_count; i++)
                  if (shadow_list[i] == val)
                     hits.push_back(i);
               if (hits.size() == 0)
                  push_result(ST_NOT_FOUND, 0, '0, 1'b1);
               for (i = 0; i < hits.size(); i++)
                  push_result(ST_OK, hits[i], shadow_list[hits[i]], i + 1 == hits.size());
            end
         end
         OP_PRINT: begin
            if (shadow_count == 0)
               push_result(ST_EMPTY, 0, '0, 1'b1);
            for (i = 0; i < shadow_count; i++)
               push_result(ST_OK, i, shadow_list[i], i + 1 == shadow_count);
         end
         OP_CLEAR: begin
            shadow_count = 0;
            push_result(ST_OK, 0, '0, 1'b1);
         end
         default: begin
            // unassigned opcodes are answered with a reject and leave the list alone
            push_result(ST_REJECTED, 0, '0, 1'b1);
         end
      endcase
   endtask

   task automatic check_result();
      list_result_type want;
      if (queued_results.size() == 0) begin
         report("result strobe with no request outstanding");
      end else begin
         want = queued_results.pop_front();
         if (rsp_status !== want.status)
            report($sformatf("status: want %0d got %0d", want.status, rsp_status));
         if (rsp_found_position !== want.position)
            report($sformatf("found_position: want %0d got %0d", want.position,
                             rsp_found_position));
         if (rsp_entry_value !== want.value)
            report($sformatf("entry_value: want %0d got %0d", want.value, rsp_entry_value));
         if (rsp_entry_count !== want.count)
            report($sformatf("entry_count: want %0d got %0d", want.count, rsp_entry_count));
         if (rsp_last_of_run !== want.last)
            report($sformatf("last_of_run: want %0b got %0b", want.last, rsp_last_of_run));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            apply_list_op(req_operation, req_position, req_item_value);
         if (rsp_strobe)
            check_result();
      end
      pending   = queued_results.size();
      list_size = shadow_count;
   end

endmodule

[sim/positional_array_list_test.sv]
// Top of the list testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module positional_array_list_test;
   import pal_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [OP_W-1:0]            req_operation;
   logic [POS_W-1:0]           req_position;
   logic signed [ITEM_W-1:0]   req_item_value;
   logic                       rsp_strobe;
   logic [STATUS_W-1:0]        rsp_status;
   logic [POS_W-1:0]           rsp_found_position;
   logic signed [ITEM_W-1:0]   rsp_entry_value;
   logic [COUNT_W-1:0]         rsp_entry_count;
   logic                       rsp_last_of_run;
   int                         fail_count;
   int                         pending;
   int                         list_size;
   int                         idle_pct;
   logic signed [ITEM_W-1:0]   value_pool [8];

   positional_array_list uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_position(req_position),
      .req_item_value(req_item_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_found_position(rsp_found_position),
      .rsp_entry_value(rsp_entry_value),
      .rsp_entry_count(rsp_entry_count),
      .rsp_last_of_run(rsp_last_of_run)
   );

   positional_array_list_checker u_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_position(req_position),
      .req_item_value(req_item_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_found_position(rsp_found_position),
      .rsp_entry_value(rsp_entry_value),
      .rsp_entry_count(rsp_entry_count),
      .rsp_last_of_run(rsp_last_of_run),
      .fail_count(fail_count),
      .pending(pending),
      .list_size(list_size)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // start stays high from one request to the next unless the sender idles
   task automatic send(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                       input logic signed [ITEM_W-1:0] val);
      @(negedge clock);
      start          <= 1'b1;
      req_operation  <= op;
      req_position   <= pos;
      req_item_value <= val;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   function automatic logic signed [ITEM_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 6)
         return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic random_request();
      int               pick;
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      pick = $urandom_range(0, 99);
      if (pick < 38)
         op = OP_INSERT;
      else if (pick < 60)
         op = OP_DELETE;
      else if (pick < 72)
         op = OP_RETRIEVE;
      else if (pick < 86)
         op = OP_LOCATE;
      else if (pick < 96)
         op = OP_PRINT;
      else
         op = OP_CLEAR;
      // mostly positions the list can honor, the rest anywhere
      if ($urandom_range(0, 9) < 8)
         pos = POS_W'($urandom_range(0, list_size > 15 ? 15 : list_size));
      else
         pos = POS_W'($urandom_range(0, 15));
      send(op, pos, pick_value());
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_operation  <= OP_INSERT;
      req_position   <= '0;
      req_item_value <= '0;
      idle_pct = 0;
      value_pool[0] = 0;
      value_pool[1] = -1;
      value_pool[2] = 1;
      value_pool[3] = 32'sh7fffffff;
      value_pool[4] = 32'sh80000000;
      value_pool[5] = $urandom;
      value_pool[6] = $urandom;
      value_pool[7] = 42;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list, then a small list with duplicates and extreme values
      send(OP_LOCATE, 0, 5);
      send(OP_PRINT, 0, 0);
      send(OP_DELETE, 0, 0);
      send(OP_RETRIEVE, 15, 0);
      send(OP_INSERT, 1, 32'sh12345678);
      send(OP_INSERT, 0, 32'sh7fffffff);
      send(OP_INSERT, 0, 32'sh80000000);
      send(OP_INSERT, 2, 0);
      send(OP_INSERT, 1, -1);
      send(OP_INSERT, 0, 32'sh7fffffff);
      send(OP_RETRIEVE, 4, 0);
      send(OP_RETRIEVE, 5, 0);
      send(OP_RETRIEVE, 0, 0);
      send(OP_LOCATE, 0, 32'sh7fffffff);
      send(OP_LOCATE, 0, 7);
      send(OP_PRINT, 0, 0);
      send(OP_DELETE, 1, 0);
      send(OP_DELETE, 15, 0);
      send(OP_DELETE, 3, 0);
      send(OP_SPARE_LO, 3, -1);
      send(OP_SPARE_HI, 15, 32'sh7fffffff);
      send(OP_INSERT, 15, 9);
      send(OP_CLEAR, 0, 0);
      send(OP_PRINT, 0, 0);
      send(OP_INSERT, 0, 32'sh5a5a5a5a);
      drain();

      // fill to capacity and work the full list
      while (list_size < DEF_CAPACITY)
         send(OP_INSERT, POS_W'($urandom_range(0, list_size)), pick_value());
      send(OP_INSERT, 0, pick_value());
      send(OP_LOCATE, 0, value_pool[$urandom_range(0, 7)]);
      send(OP_PRINT, 0, 0);
      send(OP_RETRIEVE, 15, 0);
      send(OP_DELETE, 15, 0);
      send(OP_INSERT, 15, pick_value());

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: idle_pct = 0;
            1: idle_pct = 83;
            2: idle_pct = 15;
            default: idle_pct = 0;
         endcase
         repeat (48)
            random_request();
         drain();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
design/pal_pkg.sv
design/pal_cell.sv
design/pal_chain.sv
design/positional_array_list.sv
sim/positional_array_list_checker.sv
sim/positional_array_list_test.sv
